[rtl/core/sisu_pkg.sv]
// Shared types, constants and helpers for the sparse index set update unit.
`timescale 1ns / 1ps

package sisu_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned IDX_W   = $clog2(MAX_LEN);
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned VMEM_W  = VAL_W + IDX_W;  // {list position, raw value}

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // configuration register indexes
  localparam logic REG_LENGTH = 1'b0;

  localparam logic [CNT_W-1:0] LENGTH_RESET = CNT_W'(MAX_LEN);

  typedef struct packed {
    logic [VAL_W-1:0] old_value;
    logic [CNT_W-1:0] nonzero_total;
    logic [IDX_W-1:0] list_entry;
    logic [IDX_W-1:0] index_slot;
    logic             status;
  } result_t;

  // +0 and -0 both count as zero: only the sign bit may be set
  function automatic logic is_zero(input logic [VAL_W-1:0] v);
    return v[VAL_W-2:0] == '0;
  endfunction

endpackage

[rtl/core/sisu_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps

module sisu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sparse_index_set_update_unit.sv]
// Top level of the sparse index set update unit: dense value store plus nonzero index list.
`timescale 1ns / 1ps

// Sparse set over a 1024-entry vector of raw 64-bit doubles. Two RAMs hold the
// state: the element RAM keeps {list position, value} per index, the list RAM
// keeps the packed list of nonzero indices. One request is worked on at a time.
// Reads and writes that move no other list entry go through a RAM read, then
// update and result; a write that turns a nonzero into zero and moves another
// list entry adds a further step, the read-modify-write of the moved index's
// map field in the element RAM. Rejected requests, the unused request code and
// a clear of an empty list are answered from the idle state. A clear walks the
// list one entry per cycle, through the list RAM read port. A new request is
// taken while the previous result still waits on the output register.
// After reset the element RAM is swept to zero, one entry per cycle, so no
// request is taken until the sweep is done; the length register can be written
// throughout. Read and write indices at or above the length register value come
// back with status 1 and change nothing.

module sparse_index_set_update_unit
  import sisu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  // request channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [IDX_W-1:0] elem_index_i,
  input  logic [VAL_W-1:0] new_value_i,
  input  logic [IDX_W-1:0] list_pos_i,

  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] old_value_o,
  output logic [CNT_W-1:0] nonzero_total_o,
  output logic [IDX_W-1:0] list_entry_o,
  output logic [IDX_W-1:0] index_slot_o,
  output logic             status_o,

  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // controller states
  localparam logic [2:0] S_INIT = 3'd0;  // sweep element RAM to zero
  localparam logic [2:0] S_IDLE = 3'd1;  // wait for a request, issue RAM reads
  localparam logic [2:0] S_EXEC = 3'd2;  // RAM data back: update and result
  localparam logic [2:0] S_FIX  = 3'd3;  // rewrite map field of moved index
  localparam logic [2:0] S_CLR  = 3'd4;  // walk the list, zero listed values
  localparam logic [2:0] S_OUT  = 3'd5;  // result waits for output register

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] length_q, length_d;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    length_d = length_q;
    if (cfg_wr && paddr[2] == REG_LENGTH) begin
      length_d = pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LENGTH) ? 32'(length_q) : 32'd0;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] init_q, init_d;     // sweep address after reset
  logic [IDX_W-1:0] k_q, k_d;           // list position read last cycle in a clear
  logic [CNT_W-1:0] count_q, count_d;   // nonzero count
  logic             out_valid_q, out_valid_d;

  // request and scratch registers (payload, no reset)
  logic [1:0]       req_q, req_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] nv_q, nv_d;
  logic [IDX_W-1:0] lpos_q, lpos_d;
  logic [IDX_W-1:0] pos_q, pos_d;       // freed list slot
  logic [IDX_W-1:0] last_q, last_d;     // index moved into the freed slot
  result_t          res_q, res_d;
  result_t          out_q, out_d;

  // ---------------------------------------------------------------------------
  // RAMs
  // ---------------------------------------------------------------------------
  logic              vmem_we;
  logic [IDX_W-1:0]  vmem_waddr, vmem_raddr;
  logic [VMEM_W-1:0] vmem_wdata, vmem_rdata;
  logic              lmem_we;
  logic [IDX_W-1:0]  lmem_waddr, lmem_raddr, lmem_wdata, lmem_rdata;

  sisu_ram #(
    .WIDTH (VMEM_W),
    .DEPTH (MAX_LEN)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (vmem_we),
    .waddr_i (vmem_waddr),
    .wdata_i (vmem_wdata),
    .raddr_i (vmem_raddr),
    .rdata_o (vmem_rdata)
  );

  sisu_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_LEN)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lmem_we),
    .waddr_i (lmem_waddr),
    .wdata_i (lmem_wdata),
    .raddr_i (lmem_raddr),
    .rdata_o (lmem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Datapath decode of RAM read data
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] old_v;
  logic [IDX_W-1:0] old_pos;
  logic             old_zero, new_zero;
  logic             do_append, do_remove;
  logic             in_acc, out_free;
  logic             in_reject;
  logic             clr_more;
  logic             done_c;      // result ready this cycle
  result_t          res_c;

  assign old_v    = vmem_rdata[VAL_W-1:0];
  assign old_pos  = vmem_rdata[VMEM_W-1:VAL_W];
  assign old_zero = is_zero(old_v);
  assign new_zero = is_zero(nv_q);

  // zero -> nonzero appends, nonzero -> zero swaps the last entry in
  assign do_append = (req_q == REQ_WRITE) && old_zero && !new_zero &&
                     (count_q < CNT_W'(MAX_LEN));
  assign do_remove = (req_q == REQ_WRITE) && !old_zero && new_zero &&
                     (count_q != '0);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_reject  = (req_type_i == REQ_WRITE || req_type_i == REQ_READ) &&
                      ({1'b0, elem_index_i} >= length_q);
  assign clr_more   = ({1'b0, k_q} + 1'b1) < count_q;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    k_d         = k_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    idx_d       = idx_q;
    nv_d        = nv_q;
    lpos_d      = lpos_q;
    pos_d       = pos_q;
    last_d      = last_q;
    res_d       = res_q;
    out_d       = out_q;

    vmem_we    = 1'b0;
    vmem_waddr = idx_q;
    vmem_wdata = {old_pos, nv_q};
    vmem_raddr = idx_q;
    lmem_we    = 1'b0;
    lmem_waddr = count_q[IDX_W-1:0];
    lmem_wdata = idx_q;
    lmem_raddr = k_q;

    done_c = 1'b0;
    res_c  = '{old_value: '0, nonzero_total: count_q, list_entry: '0,
               index_slot: '0, status: STATUS_OK};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        vmem_we    = 1'b1;
        vmem_waddr = init_q;
        vmem_wdata = '0;
        init_d     = init_q + 1'b1;
        if (init_q == IDX_W'(MAX_LEN - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        // reads go out straight from the request ports
        vmem_raddr = elem_index_i;
        if (req_type_i == REQ_READ) begin
          lmem_raddr = list_pos_i;
        end else if (req_type_i == REQ_CLEAR) begin
          lmem_raddr = '0;
        end else begin
          lmem_raddr = IDX_W'(count_q - 1'b1);
        end
        if (in_acc) begin
          req_d  = req_type_i;
          idx_d  = elem_index_i;
          nv_d   = new_value_i;
          lpos_d = list_pos_i;
          k_d    = '0;
          if (in_reject) begin
            done_c       = 1'b1;
            res_c.status = STATUS_RANGE;
          end else if (req_type_i == REQ_WRITE || req_type_i == REQ_READ) begin
            state_d = S_EXEC;
          end else if (req_type_i == REQ_CLEAR && count_q != '0) begin
            state_d = S_CLR;
          end else begin
            done_c = 1'b1;   // empty clear or unused code
          end
        end
      end

      S_EXEC: begin
        res_c.old_value = old_v;
        if (req_q == REQ_WRITE) begin
          vmem_we    = 1'b1;
          vmem_waddr = idx_q;
          vmem_wdata = {(do_append ? count_q[IDX_W-1:0] : old_pos), nv_q};
          if (do_append) begin
            lmem_we    = 1'b1;
            lmem_waddr = count_q[IDX_W-1:0];
            lmem_wdata = idx_q;
            count_d    = count_q + 1'b1;
          end else if (do_remove) begin
            lmem_we    = 1'b1;
            lmem_waddr = old_pos;
            lmem_wdata = lmem_rdata;
            count_d    = count_q - 1'b1;
          end
          res_c.nonzero_total = count_d;
          if (!new_zero) begin
            res_c.index_slot = do_append ? count_q[IDX_W-1:0] : old_pos;
          end
          // moved entry needs its map field rewritten: fetch its value now
          vmem_raddr = lmem_rdata;
          pos_d      = old_pos;
          last_d     = lmem_rdata;
          if (do_remove && lmem_rdata != idx_q) begin
            res_d   = res_c;
            state_d = S_FIX;
          end else begin
            done_c = 1'b1;
          end
        end else begin
          if ({1'b0, lpos_q} < count_q) begin
            res_c.list_entry = lmem_rdata;
          end
          if (!old_zero) begin
            res_c.index_slot = old_pos;
          end
          done_c = 1'b1;
        end
      end

      S_FIX: begin
        vmem_we    = 1'b1;
        vmem_waddr = last_q;
        vmem_wdata = {pos_q, old_v};
        done_c     = 1'b1;
      end

      S_CLR: begin
        vmem_we    = 1'b1;
        vmem_waddr = lmem_rdata;
        vmem_wdata = '0;
        lmem_raddr = IDX_W'(k_q + 1'b1);
        if (clr_more) begin
          k_d = IDX_W'(k_q + 1'b1);
        end else begin
          count_d             = '0;
          res_c.nonzero_total = '0;
          done_c              = 1'b1;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // deliver a finished result, or park it until the output frees up
    if (done_c) begin
      if (out_free) begin
        out_d       = (state_q == S_FIX) ? res_q : res_c;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        if (state_q != S_FIX) begin
          res_d = res_c;
        end
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      k_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      length_q    <= LENGTH_RESET;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      k_q         <= k_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      length_q    <= length_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    nv_q   <= nv_d;
    lpos_q <= lpos_d;
    pos_q  <= pos_d;
    last_q <= last_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign old_value_o     = out_q.old_value;
  assign nonzero_total_o = out_q.nonzero_total;
  assign list_entry_o    = out_q.list_entry;
  assign index_slot_o    = out_q.index_slot;
  assign status_o        = out_q.status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_LEN))
    else $error("nonzero count beyond vector length");

  a_fix_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIX |-> $past(state_q) == S_EXEC)
    else $error("map fixup without a preceding update");

  a_count_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(state_q) == S_EXEC || $past(state_q) == S_CLR)
    else $error("nonzero count changed outside update or clear");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR && !clr_more |=> count_q == '0)
    else $error("clear left entries listed");

endmodule
